// ----- rtl/gbcd_pkg.sv -----
// Package for the grid climbing distance search block.
// Holds default sizes, register indexes, state codes and output limits.
// No dependencies.
package gbcd_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 256;

    localparam int EPOCH_W  = 8;
    localparam int DIST_W   = 14;
    localparam int BOUND_W  = 11;

    localparam logic [1:0] REG_GRID_ROWS  = 2'd0;
    localparam logic [1:0] REG_GRID_COLS  = 2'd1;
    localparam logic [1:0] REG_TARGET_ROW = 2'd2;
    localparam logic [1:0] REG_TARGET_COL = 2'd3;

    localparam logic [DIST_W-1:0] DIST_SAT = '1;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_POP   = 8'b0000_0100,
        ST_CUR   = 8'b0000_1000,
        ST_CURH  = 8'b0001_0000,
        ST_NB    = 8'b0010_0000,
        ST_NBCHK = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

endpackage

// ----- rtl/gbcd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gbcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/grid_bfs_climb_distance_top.sv -----
// Top level of the grid climbing distance search block.
// Depends on gbcd_pkg and gbcd_ram.
//
// Usage:
//   The slave stream carries requests. tuser is the command: load writes one
//   cell height, search runs a breadth-first search from the given cell.
//   A load gives no result. A search gives one result on
//   the master stream: reached flag, distance, and the best distance over all
//   searches since the last load.
//   The configuration port sets grid size and target; write it while idle.
//   A search walks ST_POP, ST_CUR and ST_CURH for each visited cell, then
//   ST_NB for each neighbor and ST_NBCHK for each neighbor inside the grid,
//   an order set by the single read port of the height and visited memories.
//   Visited marks use an epoch tag; every 255 searches, and after reset, a
//   clearing pass over all MAX_ROWS*MAX_COLS entries (each rounded up to a
//   power of two) runs while no request is taken.
//   The result sits in an output register; while the receiver stalls, loads
//   are still taken, but a finished search waits until the register is free.
module grid_bfs_climb_distance_top #(
    parameter int MAX_ROWS = gbcd_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gbcd_pkg::DEF_MAX_COLS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [5:0] cell_row, [13:6] cell_col, [18:14] cell_height, zero pad
    input  logic [23:0] s_axis_tdata,
    // [0] command
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] reached, [14:1] distance, [15] best_found, [29:16] best_distance
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    import gbcd_pkg::*;

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW = RW + CW;
    localparam int QW = 2 * AW;
    localparam int DEPTH = 2 ** AW;
    localparam logic [BOUND_W-1:0] MAX_ROWS_B = BOUND_W'(MAX_ROWS);
    localparam logic [BOUND_W-1:0] MAX_COLS_B = BOUND_W'(MAX_COLS);

    state_t state_reg, state_next;

    logic [6:0] grid_rows_reg;
    logic [8:0] grid_cols_reg;
    logic [5:0] target_row_reg;
    logic [7:0] target_col_reg;

    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [AW:0]        head_reg, head_next;
    logic [AW:0]        tail_reg, tail_next;
    logic [AW-1:0]      cur_reg, cur_next;
    logic [AW-1:0]      d_reg, d_next;
    logic [4:0]         h_reg, h_next;
    logic [1:0]         k_reg, k_next;
    logic [AW-1:0]      nb_reg, nb_next;
    logic               hit_reg, hit_next;
    logic [AW-1:0]      dist_reg, dist_next;
    logic               best_valid_reg, best_valid_next;
    logic [DIST_W-1:0]  best_reg, best_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_data_reg, out_data_next;

    logic [BOUND_W-1:0] rows_eff, cols_eff;
    logic [BOUND_W-1:0] row_in_b, col_in_b;
    logic               in_store, in_grid, tgt_ok, accept;
    logic [AW-1:0]      in_addr;

    logic               h_we, v_we, q_we;
    logic [AW-1:0]      h_waddr, h_raddr, v_waddr, q_waddr;
    logic [4:0]         h_wdata, h_rdata;
    logic [EPOCH_W-1:0] v_wdata, v_rdata;
    logic [QW-1:0]      q_wdata, q_rdata;

    logic [RW-1:0]      cur_r, nb_r;
    logic [CW-1:0]      cur_c, nb_c;
    logic               nb_ok;
    logic [AW-1:0]      nb_addr;
    logic [AW-1:0]      q_cur;
    logic [AW-1:0]      q_d;
    logic               is_target;
    logic               climb_ok;
    logic [31:0]        d_wide;
    logic [DIST_W-1:0]  dist_sat;
    logic               out_free;

    always_comb
    begin
        if (grid_rows_reg == 7'd0)
        begin
            rows_eff = BOUND_W'(1);
        end
        else if (BOUND_W'(grid_rows_reg) > MAX_ROWS_B)
        begin
            rows_eff = MAX_ROWS_B;
        end
        else
        begin
            rows_eff = BOUND_W'(grid_rows_reg);
        end
        if (grid_cols_reg == 9'd0)
        begin
            cols_eff = BOUND_W'(1);
        end
        else if (BOUND_W'(grid_cols_reg) > MAX_COLS_B)
        begin
            cols_eff = MAX_COLS_B;
        end
        else
        begin
            cols_eff = BOUND_W'(grid_cols_reg);
        end
    end

    assign row_in_b = BOUND_W'(s_axis_tdata[5:0]);
    assign col_in_b = BOUND_W'(s_axis_tdata[13:6]);
    assign in_store = (row_in_b < MAX_ROWS_B) && (col_in_b < MAX_COLS_B);
    assign in_grid  = (row_in_b < rows_eff) && (col_in_b < cols_eff);
    assign tgt_ok   = (BOUND_W'(target_row_reg) < rows_eff)
                   && (BOUND_W'(target_col_reg) < cols_eff);
    assign in_addr  = {row_in_b[RW-1:0], col_in_b[CW-1:0]};

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign cur_r = cur_reg[AW-1:CW];
    assign cur_c = cur_reg[CW-1:0];

    always_comb
    begin
        nb_r  = cur_r;
        nb_c  = cur_c;
        nb_ok = 1'b0;
        case (k_reg)
            DIR_UP:
            begin
                nb_ok = (cur_r != '0);
                nb_r  = cur_r - RW'(1);
            end
            DIR_LEFT:
            begin
                nb_ok = (cur_c != '0);
                nb_c  = cur_c - CW'(1);
            end
            DIR_RIGHT:
            begin
                nb_ok = (BOUND_W'(cur_c) + BOUND_W'(1)) < cols_eff;
                nb_c  = cur_c + CW'(1);
            end
            DIR_DOWN:
            begin
                nb_ok = (BOUND_W'(cur_r) + BOUND_W'(1)) < rows_eff;
                nb_r  = cur_r + RW'(1);
            end
            default:
            begin
                nb_ok = 1'b0;
            end
        endcase
    end

    assign nb_addr = {nb_r, nb_c};
    assign q_cur   = q_rdata[QW-1:AW];
    assign q_d     = q_rdata[AW-1:0];
    assign is_target = (BOUND_W'(q_cur[AW-1:CW]) == BOUND_W'(target_row_reg))
                    && (BOUND_W'(q_cur[CW-1:0]) == BOUND_W'(target_col_reg));
    assign climb_ok = {1'b0, h_rdata} <= ({1'b0, h_reg} + 6'd1);
    assign d_wide   = 32'(dist_reg);
    assign dist_sat = (d_wide > 32'(DIST_SAT)) ? DIST_SAT : d_wide[DIST_W-1:0];
    assign out_free = !out_valid_reg || m_axis_tready;

    assign h_raddr = (state_reg == ST_CUR) ? q_cur : nb_addr;

    always_comb
    begin
        state_next      = state_reg;
        epoch_next      = epoch_reg;
        clr_next        = clr_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cur_next        = cur_reg;
        d_next          = d_reg;
        h_next          = h_reg;
        k_next          = k_reg;
        nb_next         = nb_reg;
        hit_next        = hit_reg;
        dist_next       = dist_reg;
        best_valid_next = best_valid_reg;
        best_next       = best_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        h_we    = 1'b0;
        h_waddr = in_addr;
        h_wdata = s_axis_tdata[18:14];
        v_we    = 1'b0;
        v_waddr = nb_reg;
        v_wdata = epoch_reg;
        q_we    = 1'b0;
        q_waddr = tail_reg[AW-1:0];
        q_wdata = {nb_reg, d_reg + AW'(1)};

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                v_we    = 1'b1;
                v_waddr = clr_reg;
                v_wdata = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == '1)
                begin
                    epoch_next = EPOCH_W'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tuser == CMD_LOAD)
                    begin
                        h_we            = in_store;
                        best_valid_next = 1'b0;
                        best_next       = '0;
                    end
                    else if (in_grid && tgt_ok)
                    begin
                        v_we      = 1'b1;
                        v_waddr   = in_addr;
                        q_we      = 1'b1;
                        q_waddr   = '0;
                        q_wdata   = {in_addr, AW'(0)};
                        head_next = '0;
                        tail_next = (AW + 1)'(1);
                        state_next = ST_POP;
                    end
                    else
                    begin
                        hit_next   = 1'b0;
                        dist_next  = '0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    hit_next   = 1'b0;
                    dist_next  = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    head_next  = head_reg + (AW + 1)'(1);
                    state_next = ST_CUR;
                end
            end
            ST_CUR:
            begin
                cur_next = q_cur;
                d_next   = q_d;
                if (is_target)
                begin
                    hit_next   = 1'b1;
                    dist_next  = q_d;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_CURH;
                end
            end
            ST_CURH:
            begin
                h_next     = h_rdata;
                k_next     = DIR_UP;
                state_next = ST_NB;
            end
            ST_NB:
            begin
                nb_next = nb_addr;
                if (nb_ok)
                begin
                    state_next = ST_NBCHK;
                end
                else if (k_reg == DIR_DOWN)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            ST_NBCHK:
            begin
                if ((v_rdata != epoch_reg) && climb_ok)
                begin
                    v_we      = 1'b1;
                    q_we      = 1'b1;
                    tail_next = tail_reg + (AW + 1)'(1);
                end
                if (k_reg == DIR_DOWN)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_NB;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    if (hit_reg && (!best_valid_reg || dist_sat < best_reg))
                    begin
                        best_next = dist_sat;
                    end
                    if (hit_reg)
                    begin
                        best_valid_next = 1'b1;
                    end
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00,
                                      (hit_reg && (!best_valid_reg || dist_sat < best_reg))
                                          ? dist_sat : best_reg,
                                      hit_reg || best_valid_reg,
                                      hit_reg ? dist_sat : DIST_SAT & '0,
                                      hit_reg};
                    epoch_next = epoch_reg + EPOCH_W'(1);
                    clr_next   = '0;
                    state_next = (epoch_reg == '1) ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            epoch_reg      <= EPOCH_W'(1);
            clr_reg        <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            k_reg          <= DIR_UP;
            hit_reg        <= 1'b0;
            best_valid_reg <= 1'b0;
            best_reg       <= '0;
            out_valid_reg  <= 1'b0;
            grid_rows_reg  <= 7'd64;
            grid_cols_reg  <= 9'd256;
            target_row_reg <= '0;
            target_col_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            epoch_reg      <= epoch_next;
            clr_reg        <= clr_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            k_reg          <= k_next;
            hit_reg        <= hit_next;
            best_valid_reg <= best_valid_next;
            best_reg       <= best_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GRID_ROWS:  grid_rows_reg  <= cfg_data[6:0];
                    REG_GRID_COLS:  grid_cols_reg  <= cfg_data;
                    REG_TARGET_ROW: target_row_reg <= cfg_data[5:0];
                    REG_TARGET_COL: target_col_reg <= cfg_data[7:0];
                    default:        grid_rows_reg  <= grid_rows_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        d_reg        <= d_next;
        h_reg        <= h_next;
        nb_reg       <= nb_next;
        dist_reg     <= dist_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    gbcd_ram #(
        .WIDTH (5),
        .DEPTH (DEPTH)
    ) u_height (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    gbcd_ram #(
        .WIDTH (EPOCH_W),
        .DEPTH (DEPTH)
    ) u_visited (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (nb_addr),
        .rdata (v_rdata)
    );

    gbcd_ram #(
        .WIDTH (QW),
        .DEPTH (DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (head_reg[AW-1:0]),
        .rdata (q_rdata)
    );

endmodule

// ----- tb/tb_top.sv -----
// Testbench for grid_bfs_climb_distance_top: loads height grids, runs searches and
// checks each result against a breadth-first search predictor kept in the bench or a fixed expected value.
// Depends on gbcd_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
    import gbcd_pkg::*;

    localparam int ROWS_CAP   = 64;
    localparam int COLS_CAP   = 256;
    localparam int CELL_COUNT = ROWS_CAP * COLS_CAP;
    localparam int ITEM_GOAL  = 1050;
    localparam int STALL_LIMIT = 100000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic              reached;
        logic [DIST_W-1:0] distance;
        logic              found;
        logic [DIST_W-1:0] best;
    } climb_result_t;

    typedef struct {
        logic              cmd;
        logic [5:0]        row;
        logic [7:0]        col;
        logic [4:0]        height;
        bit                typed;
        climb_result_t     res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [8:0]  cfg_data;

    grid_bfs_climb_distance_top uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // mirror of the block's grid and registers
    logic [4:0]    heights [CELL_COUNT];
    int            seen_tag [CELL_COUNT];
    int            frontier_cell [CELL_COUNT];
    int            frontier_steps [CELL_COUNT];
    int            search_tag;
    int            rows_in_use;
    int            cols_in_use;
    int            goal_row;
    int            goal_col;
    logic [DIST_W-1:0] best_dist;
    bit            best_ok;

    climb_result_t pending_results[$];
    int            sent_count;
    int            mismatch_count;
    int            snd_idle_pct;
    int            rcv_idle_pct;
    int            hold_left;
    bit            hold_done;
    int            quiet_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int clamp_dim(input int v, input int cap);
        if (v == 0) return 1;
        if (v > cap) return cap;
        return v;
    endfunction

    function automatic climb_result_t predict_search(input int sr, input int sc);
        climb_result_t res;
        int head;
        int tail;
        int cur;
        int r;
        int c;
        int nr;
        int nc;
        int nidx;
        int d;
        bit hit;
        res = '0;
        hit = 1'b0;
        d = 0;
        if (sr < rows_in_use && sc < cols_in_use && goal_row < rows_in_use
                && goal_col < cols_in_use) begin
            search_tag++;
            head = 0;
            tail = 1;
            frontier_cell[0] = sr * COLS_CAP + sc;
            frontier_steps[0] = 0;
            seen_tag[sr * COLS_CAP + sc] = search_tag;
            while (head < tail && !hit) begin
                cur = frontier_cell[head];
                r = cur / COLS_CAP;
                c = cur % COLS_CAP;
                if (r == goal_row && c == goal_col) begin
                    hit = 1'b1;
                    d = frontier_steps[head];
                end
                else begin
                    for (int k = 0; k < 4; k++) begin
                        nr = r + ((k == 0) ? -1 : (k == 3) ? 1 : 0);
                        nc = c + ((k == 1) ? -1 : (k == 2) ? 1 : 0);
                        if (nr >= 0 && nc >= 0 && nr < rows_in_use && nc < cols_in_use) begin
                            nidx = nr * COLS_CAP + nc;
                            if (seen_tag[nidx] != search_tag
                                    && int'(heights[nidx]) <= int'(heights[cur]) + 1) begin
                                seen_tag[nidx] = search_tag;
                                frontier_cell[tail] = nidx;
                                frontier_steps[tail] = frontier_steps[head] + 1;
                                tail++;
                            end
                        end
                    end
                end
                head++;
            end
        end
        if (hit) begin
            if (d > 16383) d = 16383;
            if (!best_ok || d < int'(best_dist)) best_dist = DIST_W'(d);
            best_ok = 1'b1;
            res.reached = 1'b1;
            res.distance = DIST_W'(d);
        end
        res.found = best_ok;
        res.best = best_ok ? best_dist : '0;
        return res;
    endfunction

    task automatic send_request(input logic cmd, input int row, input int col,
                                input int height, input bit typed,
                                input climb_result_t typed_res);
        climb_result_t res;
        if ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < snd_idle_pct) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {5'd0, height[4:0], col[7:0], row[5:0]};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sent_count++;
        if (cmd == CMD_LOAD) begin
            heights[row * COLS_CAP + col] = height[4:0];
            best_ok = 1'b0;
            best_dist = '0;
        end
        else begin
            res = predict_search(row, col);
            pending_results.push_back(typed ? typed_res : res);
        end
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_grid(input int rows, input int cols, input int trow, input int tcol);
        cfg_we <= 1'b1;
        cfg_index <= REG_GRID_ROWS;
        cfg_data <= 9'(rows);
        @(posedge clk);
        cfg_index <= REG_GRID_COLS;
        cfg_data <= 9'(cols);
        @(posedge clk);
        cfg_index <= REG_TARGET_ROW;
        cfg_data <= 9'(trow);
        @(posedge clk);
        cfg_index <= REG_TARGET_COL;
        cfg_data <= 9'(tcol);
        @(posedge clk);
        cfg_we <= 1'b0;
        rows_in_use = clamp_dim(rows, ROWS_CAP);
        cols_in_use = clamp_dim(cols, COLS_CAP);
        goal_row = trow;
        goal_col = tcol;
    endtask

    task automatic update_idling;
        if (sent_count < ITEM_GOAL / 3) begin
            snd_idle_pct = 27;
            rcv_idle_pct = 82;
        end
        else if (sent_count < 2 * ITEM_GOAL / 3) begin
            snd_idle_pct = 82;
            rcv_idle_pct = 27;
        end
        else begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
        end
    endtask

    // load every cell of the grid in use, then mix searches with reloads
    task automatic run_phase(input int rows, input int cols, input int trow,
                             input int tcol, input int searches);
        int h;
        int r;
        int c;
        drain();
        set_grid(rows, cols, trow, tcol);
        for (int i = 0; i < rows_in_use; i++) begin
            for (int j = 0; j < cols_in_use; j++) begin
                update_idling();
                h = ($urandom_range(99) < 90) ? $urandom_range(3) : $urandom_range(31);
                send_request(CMD_LOAD, i, j, h, 1'b0, '0);
            end
        end
        for (int n = 0; n < searches; n++) begin
            update_idling();
            if ($urandom_range(99) < 10) begin
                r = $urandom_range(63);
                c = $urandom_range(255);
            end
            else begin
                r = $urandom_range(rows_in_use - 1);
                c = $urandom_range(cols_in_use - 1);
            end
            h = ($urandom_range(99) < 85) ? $urandom_range(4) : $urandom_range(31);
            send_request(($urandom_range(99) < 25) ? CMD_LOAD : CMD_SEARCH, r, c, h,
                         1'b0, '0);
        end
    endtask

    stim_row_t directed[] = '{
        '{CMD_LOAD,   6'd0,  8'd0,   5'd0,  1'b0, '0},
        '{CMD_LOAD,   6'd0,  8'd1,   5'd1,  1'b0, '0},
        '{CMD_LOAD,   6'd1,  8'd0,   5'd25, 1'b0, '0},
        '{CMD_LOAD,   6'd1,  8'd1,   5'd2,  1'b0, '0},
        '{CMD_SEARCH, 6'd1,  8'd1,   5'd0,  1'b1, '{1'b1, 14'd0, 1'b1, 14'd0}},
        '{CMD_SEARCH, 6'd0,  8'd0,   5'd0,  1'b1, '{1'b1, 14'd2, 1'b1, 14'd0}},
        '{CMD_SEARCH, 6'd63, 8'd255, 5'd31, 1'b1, '{1'b0, 14'd0, 1'b1, 14'd0}},
        '{CMD_SEARCH, 6'd0,  8'd2,   5'd0,  1'b1, '{1'b0, 14'd0, 1'b1, 14'd0}},
        '{CMD_SEARCH, 6'd1,  8'd0,   5'd0,  1'b0, '0},
        '{CMD_LOAD,   6'd1,  8'd0,   5'd31, 1'b0, '0},
        '{CMD_SEARCH, 6'd0,  8'd0,   5'd0,  1'b0, '0},
        '{CMD_SEARCH, 6'd1,  8'd0,   5'd0,  1'b0, '0},
        '{CMD_LOAD,   6'd63, 8'd255, 5'd31, 1'b0, '0},
        '{CMD_SEARCH, 6'd0,  8'd1,   5'd0,  1'b0, '0}
    };

    always @(posedge clk) begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %h", m_axis_tdata);
                end
                else begin
                    if (m_axis_tdata[0] !== pending_results[0].reached
                            || m_axis_tdata[14:1] !== pending_results[0].distance
                            || m_axis_tdata[15] !== pending_results[0].found
                            || m_axis_tdata[29:16] !== pending_results[0].best) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     pending_results[0].reached, pending_results[0].distance,
                                     pending_results[0].found, pending_results[0].best,
                                     m_axis_tdata[0], m_axis_tdata[14:1],
                                     m_axis_tdata[15], m_axis_tdata[29:16]);
                    end
                    void'(pending_results.pop_front());
                end
            end
            if (!hold_done && sent_count >= 2 * ITEM_GOAL / 3 + 40) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else begin
                m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_GRID_ROWS;
        cfg_data = '0;
        sent_count = 0;
        mismatch_count = 0;
        quiet_cycles = 0;
        search_tag = 0;
        hold_left = 0;
        hold_done = 1'b0;
        best_ok = 1'b0;
        best_dist = '0;
        snd_idle_pct = 27;
        rcv_idle_pct = 82;
        rows_in_use = ROWS_CAP;
        cols_in_use = COLS_CAP;
        goal_row = 0;
        goal_col = 0;
        for (int i = 0; i < CELL_COUNT; i++) begin
            heights[i] = '0;
            seen_tag[i] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_grid(2, 2, 1, 1);
        foreach (directed[i])
            send_request(directed[i].cmd, directed[i].row, directed[i].col,
                         directed[i].height, directed[i].typed, directed[i].res);

        // size extremes: zero, over range, full height, full width, far target
        run_phase(0, 0, 0, 0, 6);
        run_phase(127, 1, 63, 0, 12);
        run_phase(1, 511, 0, 255, 12);
        run_phase(64, 1, 0, 0, 10);
        run_phase(1, 256, 0, 0, 10);
        run_phase(4, 4, 63, 255, 8);
        while (sent_count < ITEM_GOAL) begin
            run_phase($urandom_range(1, 8), $urandom_range(1, 16), $urandom_range(8),
                      $urandom_range(17), $urandom_range(20, 60));
        end

        drain();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
